// ===== design/ctr_pkg.sv =====
package ctr_pkg;

  localparam int unsigned BufferBytesDef   = 8192;
  localparam int unsigned MaxFrameBytesDef = 244;

  localparam logic [31:0] CrcPoly = 32'hedb88320;
  localparam logic [31:0] CrcInit = 32'hffffffff;

  localparam logic [7:0] TypeBegin = 8'h73;
  localparam logic [7:0] TypeData  = 8'h74;
  localparam logic [7:0] TypeEnd   = 8'h75;

  localparam logic [8:0] BeginBytes   = 9'd13;
  localparam logic [8:0] EndBytes     = 9'd10;
  localparam logic [8:0] DataMinBytes = 9'd9;
  localparam logic [8:0] HeadBytes    = 9'd6;

  typedef enum logic [1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_START = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REPLY_VERDICT = 2'd0,
    REPLY_START   = 2'd1,
    REPLY_READ    = 2'd2
  } reply_t;

  localparam logic [1:0] RegToken  = 2'd0;
  localparam logic [1:0] RegKind   = 2'd1;
  localparam logic [1:0] RegTarget = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [15:0] read_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic        frame_accepted;
    logic        crc_failed;
    logic        session_armed;
    logic        transfer_ready;
    logic [15:0] content_length;
    logic [7:0]  read_data;
    logic        read_valid;
  } out_t;

  // Reflected CRC-32 update over one byte, one bit per step.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== design/ctr_store.sv =====
module ctr_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/chunked_transfer_receiver_crc32.sv =====
// Chunked transfer receiver with a reflected CRC-32 check over the content.
// The input channel (in_valid, in_stall, in_data) carries one word per item:
// a frame byte with its last flag, a start-session command or a content read.
// A word is taken at a clock edge where in_valid is high and in_stall is low.
// The result channel (out_valid, out_stall, out_data) returns one word for
// each start, each read and each final frame byte; other items give none.
// A new word can be accepted every cycle while in_stall is low. The
// middle stage and the registered read port of the content memory load at the
// edge that takes the item, and the output register loads from the middle
// stage at an edge where the output may advance.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// taken and should only be made while the block is idle.
// Synchronous reset clears the session, the frame in progress and the
// registers; the content memory is not cleared and needs no clearing pass.
// When the receiver holds out_stall the output word holds, one more result can
// wait in the middle stage, and then in_stall is raised until room returns.
module chunked_transfer_receiver_crc32 #(
  parameter int unsigned BUFFER_BYTES    = ctr_pkg::BufferBytesDef,
  parameter int unsigned MAX_FRAME_BYTES = ctr_pkg::MaxFrameBytesDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ctr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ctr_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import ctr_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam logic [16:0] BufLimit = 17'(BUFFER_BYTES);
  localparam logic [8:0]  MaxFrame = 9'(MAX_FRAME_BYTES);

  // Configuration registers.
  logic [31:0] token_r, target_r;
  logic [1:0]  kind_r;

  // Session and frame state.
  logic        armed_r, armed_nxt, begun_r, begun_nxt, ready_r, ready_nxt;
  logic [15:0] total_r, total_nxt, recv_r, recv_nxt;
  logic [7:0]  fpos_r, fpos_nxt, ftype_r, ftype_nxt;
  logic        fgood_r, fgood_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [15:0] foff_r, foff_nxt;
  logic [31:0] crc_c_r, crc_c_nxt, crc_t_r, crc_t_nxt;

  // Middle stage and output register.
  logic s1_valid_r, s1_rd_r, out_valid_r;
  out_t s1_r, res, out_r;
  logic res_valid, res_rd;

  // Content memory ports.
  logic          wr_en, rd_en;
  logic [16:0]   wr_pos;
  logic [7:0]    rd_q;

  logic accept, advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r  <= '0;
      kind_r   <= '0;
      target_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegToken:  token_r  <= cfg_data;
        RegKind:   kind_r   <= cfg_data[1:0];
        RegTarget: target_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Merge the byte into the field being gathered; the first byte restarts it.
  function automatic logic [31:0] gather_in(input logic [31:0] g, input logic [7:0] p,
                                            input logic [7:0] first, input logic [7:0] b);
    logic [7:0] d;
    d = p - first;
    if (d == 8'd0) return {24'd0, b};
    return g | ({24'd0, b} << {d[1:0], 3'b000});
  endfunction

  always_comb begin
    logic [8:0]  n;
    logic [16:0] room;
    armed_nxt = armed_r;   begun_nxt = begun_r;   ready_nxt = ready_r;
    total_nxt = total_r;   recv_nxt  = recv_r;
    fpos_nxt  = fpos_r;    ftype_nxt = ftype_r;   fgood_nxt = fgood_r;
    gather_nxt = gather_r; foff_nxt  = foff_r;
    crc_c_nxt = crc_c_r;   crc_t_nxt = crc_t_r;
    res = '0;
    res_valid = 1'b0;
    res_rd = 1'b0;
    wr_en = 1'b0;
    wr_pos = {1'b0, recv_r} + 17'(fpos_r) - 17'd8;
    rd_en = 1'b0;
    n = {1'b0, fpos_r} + 9'd1;
    room = {1'b0, total_r} - {1'b0, recv_r};

    if (accept) begin
      unique case (func_t'(in_data.func))
        FUNC_START: begin
          armed_nxt = (token_r != 32'd0) &&
                      ((kind_r == 2'd1) || (kind_r == 2'd2 && target_r != 32'd0));
          begun_nxt = 1'b0; ready_nxt = 1'b0;
          total_nxt = '0;   recv_nxt = '0;
          crc_c_nxt = CrcInit; crc_t_nxt = CrcInit;
          fpos_nxt = '0; ftype_nxt = '0; fgood_nxt = 1'b1;
          gather_nxt = '0; foff_nxt = '0;
          res_valid = 1'b1;
          res.reply_kind = REPLY_START;
        end
        FUNC_READ: begin
          res_valid = 1'b1;
          res.reply_kind = REPLY_READ;
          res.read_valid = ready_r && (in_data.read_index < total_r) &&
                           ({1'b0, in_data.read_index} < BufLimit);
          res_rd = res.read_valid;
          rd_en = 1'b1;
        end
        FUNC_FRAME: begin
          if (9'(fpos_r) >= MaxFrame) fgood_nxt = 1'b0;
          if (fpos_r == 8'd0) begin
            if (in_data.frame_byte != 8'd1) fgood_nxt = 1'b0;
          end else if (fpos_r == 8'd1) begin
            ftype_nxt = in_data.frame_byte;
          end else if (fpos_r <= 8'd5) begin
            gather_nxt = gather_in(gather_r, fpos_r, 8'd2, in_data.frame_byte);
            if (fpos_r == 8'd5 && gather_nxt != token_r) fgood_nxt = 1'b0;
          end else if (ftype_r == TypeBegin) begin
            if (fpos_r == 8'd6) begin
              if (in_data.frame_byte != {6'd0, kind_r}) fgood_nxt = 1'b0;
            end else if (fpos_r <= 8'd10) begin
              gather_nxt = gather_in(gather_r, fpos_r, 8'd7, in_data.frame_byte);
              if (fpos_r == 8'd10 && gather_nxt != target_r) fgood_nxt = 1'b0;
            end else if (fpos_r <= 8'd12) begin
              gather_nxt = gather_in(gather_r, fpos_r, 8'd11, in_data.frame_byte);
            end
          end else if (ftype_r == TypeData) begin
            if (fpos_r == 8'd6) begin
              foff_nxt = {8'd0, in_data.frame_byte};
            end else if (fpos_r == 8'd7) begin
              foff_nxt = {in_data.frame_byte, foff_r[7:0]};
            end else begin
              // Payload bytes go to the store at once and into the tentative CRC.
              crc_t_nxt = crc32_byte((fpos_r == 8'd8) ? crc_c_r : crc_t_r,
                                     in_data.frame_byte);
              wr_en = (wr_pos < BufLimit) && !ready_r;
            end
          end else if (ftype_r == TypeEnd) begin
            if (fpos_r <= 8'd9) begin
              gather_nxt = gather_in(gather_r, fpos_r, 8'd6, in_data.frame_byte);
            end
          end
          fpos_nxt = (fpos_r != 8'd255) ? fpos_r + 8'd1 : 8'd255;

          if (in_data.frame_last) begin
            res_valid = 1'b1;
            res.reply_kind = REPLY_VERDICT;
            if (fgood_nxt && n >= HeadBytes && armed_r && token_r != 32'd0 && !ready_r) begin
              if (ftype_r == TypeBegin) begin
                if (n == BeginBytes && !begun_r && gather_nxt[15:0] != 16'd0 &&
                    {1'b0, gather_nxt[15:0]} <= BufLimit) begin
                  total_nxt = gather_nxt[15:0];
                  begun_nxt = 1'b1;
                  res.frame_accepted = 1'b1;
                end
              end else if (begun_r && ftype_r == TypeData) begin
                if (n >= DataMinBytes && n <= MaxFrame && foff_nxt == recv_r &&
                    17'(n - 9'd8) <= room) begin
                  recv_nxt = recv_r + 16'(n - 9'd8);
                  crc_c_nxt = crc_t_nxt;
                  res.frame_accepted = 1'b1;
                end
              end else if (begun_r && ftype_r == TypeEnd) begin
                if (n == EndBytes && recv_r == total_r) begin
                  if (gather_nxt != ~crc_c_r) begin
                    // CRC mismatch: the whole session is dropped.
                    armed_nxt = 1'b0; begun_nxt = 1'b0; ready_nxt = 1'b0;
                    total_nxt = '0;   recv_nxt = '0;
                    crc_c_nxt = CrcInit; crc_t_nxt = CrcInit;
                    res.crc_failed = 1'b1;
                  end else begin
                    ready_nxt = 1'b1;
                    res.frame_accepted = 1'b1;
                  end
                end
              end
            end
            fpos_nxt = '0; ftype_nxt = '0; fgood_nxt = 1'b1;
            gather_nxt = '0; foff_nxt = '0;
          end
        end
        default: ;
      endcase
    end
    res.session_armed  = armed_nxt;
    res.transfer_ready = ready_nxt;
    res.content_length = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0; begun_r <= 1'b0; ready_r <= 1'b0;
      total_r <= '0;   recv_r  <= '0;
      fpos_r  <= '0;   ftype_r <= '0;   fgood_r <= 1'b1;
      gather_r <= '0;  foff_r  <= '0;
      crc_c_r <= CrcInit; crc_t_r <= CrcInit;
    end else begin
      armed_r <= armed_nxt; begun_r <= begun_nxt; ready_r <= ready_nxt;
      total_r <= total_nxt; recv_r  <= recv_nxt;
      fpos_r  <= fpos_nxt;  ftype_r <= ftype_nxt; fgood_r <= fgood_nxt;
      gather_r <= gather_nxt; foff_r <= foff_nxt;
      crc_c_r <= crc_c_nxt; crc_t_r <= crc_t_nxt;
    end
  end

  ctr_store #(
    .DEPTH(BUFFER_BYTES),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_pos[AW-1:0]),
    .wr_data(in_data.frame_byte),
    .rd_en  (rd_en),
    .rd_addr(in_data.read_index[AW-1:0]),
    .rd_data(rd_q)
  );

  // Middle stage waits for the memory read; the output register follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
        s1_valid_r  <= accept && res_valid;
      end else if (accept) begin
        s1_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r    <= res;
      s1_rd_r <= res_rd;
    end
    if (advance && s1_valid_r) begin
      out_r <= s1_r;
      if (s1_rd_r) begin
        out_r.read_data <= rd_q;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  a_fail_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.crc_failed) |->
      (!out_data.session_armed && !out_data.transfer_ready && !out_data.frame_accepted))
    else $error("CRC failure did not clear the session");

  a_read_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.read_valid) |->
      (out_data.reply_kind == REPLY_READ && out_data.transfer_ready))
    else $error("read data valid outside a ready read reply");

  a_no_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !ready_r)
    else $error("content written after transfer became ready");

endmodule
